/* hw/rtl/spmdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmdq_pkg: shared definitions for the shared-pool multi-deque unit
// Sizes, operation and status codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spmdq_pkg;

  localparam int QUEUES  = 256;
  localparam int NODES   = 4096;
  localparam int QUEUE_W = $clog2(QUEUES);
  localparam int NODE_AW = $clog2(NODES);
  // A pointer also has to hold the null marker, which equals NODES.
  localparam int PTR_W   = $clog2(NODES + 1);
  localparam int VALUE_W = 32;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_POP_FRONT  = 2'd1,
    MODE_PUSH_BACK  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,
    S_NODE,
    S_LINK
  } state_t;

  typedef struct packed {
    logic [PTR_W-1:0] front;
    logic [PTR_W-1:0] back;
  } ptr_pair_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;     // take the request and read the end pointers
    logic    push_do;  // write the new node and the end pointers
    logic    node_rd;  // read the end node of the deque
    logic    pop_do;   // unlink the end node and update the pointers
    logic    link_do;  // link the old end node to the new node
    logic    emit;     // load the result register
    status_t status;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_push;
    logic pool_full;
    logic end_empty;
    logic link_needed;
    logic out_busy;
  } dp_stat_t;

endpackage

/* hw/rtl/shared_pool_multi_deque_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_pool_multi_deque_unit: many deques over one shared node pool
// Top level joining the request sequencer to the pointer and node datapath.
// ----------------------------------------------------------------------------
// Use of the block:
//   Each request on the slave stream names a deque (s_tdata) and an
//   operation (s_tuser): push front, pop front, push back or pop back. A
//   push also carries the value to store. Every request returns exactly one
//   result on the master stream: the popped value in m_tdata (zero for a
//   push or a failed pop) and a status in m_tuser: ok, pop from an empty
//   deque, or node pool exhausted. Nodes are handed out by a bump counter
//   and are never reused.
//   The pointer read happens at the accepting edge. A pop then reads its
//   end node and unlinks it before presenting its result; a push presents
//   it straight after the pointer read, or after a link step when an old end
//   node has to be linked to the new one. These dependent accesses to the
//   pointer table and the node memories mean that a new request is taken
//   only once the previous one has finished.
//   Reset empties every deque at once through one valid bit per deque and
//   clears the node counter; no clearing pass is needed.
//   A finished result waits in an output register; the next request is
//   accepted meanwhile and holds after its pointer read until the register
//   has been emptied by the receiver.
// ----------------------------------------------------------------------------
module shared_pool_multi_deque_unit import spmdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // queue_id [7:0], push_value [39:8]
  input  logic [1:0]  s_tuser,   // mode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pop_value [31:0]
  output logic [1:0]  m_tuser    // status [1:0]
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  status_t   out_status;

  // The controller sequences each request; it sees only the datapath's
  // status bundle and the input handshake.
  spmdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds all request and deque storage, including the output register.
  spmdq_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (mode_t'(s_tuser)),
    .in_queue_id   (s_tdata[QUEUE_W-1:0]),
    .in_push_value (s_tdata[39:8]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_pop_value (m_tdata),
    .out_status    (out_status)
  );

  assign m_tuser = out_status;

endmodule

/* hw/rtl/spmdq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmdq_ctrl: request sequencer
// Steps each request through pointer read, node access and link update.
// ----------------------------------------------------------------------------
module spmdq_ctrl import spmdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = STATUS_OK;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PTR;
        end
      end
      S_PTR: begin
        // Hold here until the result register is free.
        if (!stat.out_busy) begin
          if (stat.is_push) begin
            if (stat.pool_full) begin
              cmd.emit   = 1'b1;
              cmd.status = STATUS_FULL;
              state_next = S_IDLE;
            end else begin
              cmd.push_do = 1'b1;
              if (stat.link_needed) begin
                state_next = S_LINK;
              end else begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
              end
            end
          end else if (stat.end_empty) begin
            cmd.emit   = 1'b1;
            cmd.status = STATUS_EMPTY;
            state_next = S_IDLE;
          end else begin
            cmd.node_rd = 1'b1;
            state_next  = S_NODE;
          end
        end
      end
      S_NODE: begin
        cmd.pop_do = 1'b1;
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_LINK: begin
        cmd.link_do = 1'b1;
        cmd.emit    = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/spmdq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmdq_dpath: pointer table, node pool and result register
// Holds the per-deque end pointers, the linked node memories, the bump
// allocator and the output register.
// ----------------------------------------------------------------------------
module spmdq_dpath import spmdq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  input  mode_t              in_mode,
  input  logic [QUEUE_W-1:0] in_queue_id,
  input  logic [VALUE_W-1:0] in_push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_pop_value,
  output status_t            out_status
);

  // Latched request.
  mode_t              mode_r;
  logic [QUEUE_W-1:0] q_r;
  logic [VALUE_W-1:0] val_r;

  // End pointers: memory plus one valid bit per deque.
  ptr_pair_t ptr_mem [QUEUES];
  ptr_pair_t ptr_rd;
  logic [QUEUES-1:0] ptr_vld;
  logic      ptr_we;
  ptr_pair_t ptr_wdata;

  // Node pool.
  logic [VALUE_W-1:0] value_mem [NODES];
  logic [PTR_W-1:0]   next_mem  [NODES];
  logic [PTR_W-1:0]   prev_mem  [NODES];
  logic [VALUE_W-1:0] value_rd;
  logic [PTR_W-1:0]   next_rd;
  logic [PTR_W-1:0]   prev_rd;

  logic               next_we;
  logic [NODE_AW-1:0] next_waddr;
  logic [PTR_W-1:0]   next_wdata;
  logic               prev_we;
  logic [NODE_AW-1:0] prev_waddr;
  logic [PTR_W-1:0]   prev_wdata;

  logic [PTR_W-1:0] alloc;
  logic [PTR_W-1:0] new_node;

  logic             is_front;
  logic [PTR_W-1:0] front_cur;
  logic [PTR_W-1:0] back_cur;
  logic [PTR_W-1:0] end_ptr;
  logic [PTR_W-1:0] v;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      q_r    <= in_queue_id;
      val_r  <= in_push_value;
    end
  end

  always_comb begin
    is_front  = (mode_r inside {MODE_PUSH_FRONT, MODE_POP_FRONT});
    front_cur = ptr_vld[q_r] ? ptr_rd.front : NIL;
    back_cur  = ptr_vld[q_r] ? ptr_rd.back  : NIL;
    end_ptr   = is_front ? front_cur : back_cur;
    v         = alloc;

    stat.is_push     = (mode_r == MODE_PUSH_FRONT) || (mode_r == MODE_PUSH_BACK);
    stat.pool_full   = (alloc >= NIL);
    stat.end_empty   = (end_ptr == NIL);
    stat.link_needed = (front_cur != NIL) && (end_ptr != NIL);
    stat.out_busy    = out_valid;
  end

  // Pointer table writes.
  always_comb begin
    ptr_we    = cmd.push_do || cmd.pop_do;
    ptr_wdata = '{front: front_cur, back: back_cur};
    if (cmd.push_do) begin
      if (is_front) begin
        ptr_wdata.front = v;
        ptr_wdata.back  = (front_cur == NIL) ? v : back_cur;
      end else begin
        ptr_wdata.back  = v;
        ptr_wdata.front = (front_cur == NIL) ? v : front_cur;
      end
    end else if (is_front) begin
      ptr_wdata.front = next_rd;
      ptr_wdata.back  = (next_rd == NIL) ? NIL : back_cur;
    end else begin
      ptr_wdata.back  = prev_rd;
      ptr_wdata.front = (prev_rd == NIL) ? NIL : front_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (ptr_we) begin
      ptr_mem[q_r] <= ptr_wdata;
    end
    if (cmd.load) begin
      ptr_rd <= ptr_mem[in_queue_id];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_vld <= '0;
    end else if (ptr_we) begin
      ptr_vld[q_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc <= '0;
    end else if (cmd.push_do) begin
      alloc <= alloc + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_do) begin
      new_node <= v;
    end
  end

  // Link writes: the new node itself, the neighbour on a push, and the
  // surviving neighbour on a pop.
  always_comb begin
    next_we    = 1'b0;
    next_waddr = v[NODE_AW-1:0];
    next_wdata = NIL;
    prev_we    = 1'b0;
    prev_waddr = v[NODE_AW-1:0];
    prev_wdata = NIL;
    if (cmd.push_do) begin
      next_we    = 1'b1;
      next_wdata = is_front ? front_cur : NIL;
      prev_we    = 1'b1;
      prev_wdata = is_front ? NIL : back_cur;
    end else if (cmd.link_do) begin
      if (is_front) begin
        prev_we    = 1'b1;
        prev_waddr = end_ptr[NODE_AW-1:0];
        prev_wdata = new_node;
      end else begin
        next_we    = 1'b1;
        next_waddr = end_ptr[NODE_AW-1:0];
        next_wdata = new_node;
      end
    end else if (cmd.pop_do) begin
      if (is_front) begin
        prev_we    = (next_rd != NIL);
        prev_waddr = next_rd[NODE_AW-1:0];
      end else begin
        next_we    = (prev_rd != NIL);
        next_waddr = prev_rd[NODE_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_do) begin
      value_mem[v[NODE_AW-1:0]] <= val_r;
    end
    if (cmd.node_rd) begin
      value_rd <= value_mem[end_ptr[NODE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (cmd.node_rd) begin
      next_rd <= next_mem[end_ptr[NODE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (cmd.node_rd) begin
      prev_rd <= prev_mem[end_ptr[NODE_AW-1:0]];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pop_value <= cmd.pop_do ? value_rd : '0;
      out_status    <= cmd.status;
    end
  end

endmodule
